FILE: hw/rtl/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types, constants and helpers of the pressure compensation datapath
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int unsigned DIV_W = 32;
	localparam int unsigned CFG_IDX_W = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AC1_AC2   = 3'd0,
		CFG_AC3_AC4   = 3'd1,
		CFG_AC5_AC6   = 3'd2,
		CFG_B1_B2     = 3'd3,
		CFG_MC_MD     = 3'd4,
		CFG_OVERSAMPL = 3'd5
	} cfg_idx_t;

	localparam logic [31:0] C_B6_OFFSET = 32'd4000;
	localparam logic [31:0] C_P_SQ_MUL  = 32'd3038;
	localparam logic [31:0] C_P_LIN_MUL = 32'hFFFF_E343; // -7357
	localparam logic [31:0] C_P_OFFSET  = 32'd3791;
	localparam logic [31:0] C_B7_SCALE  = 32'd50000;
	localparam logic [31:0] C_X3_BIAS   = 32'd32768;
	localparam logic [31:0] C_HALF_WRAP = 32'h8000_0000;
	localparam logic [1:0]  C_OSS_RESET = 2'd3;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

FILE: hw/rtl/barometric_pressure_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// calibrated temperature and pressure from raw sensor words, integer method
// ----------------------------------------------------------------------------
// channel | signals                                   | direction
// in      | in_valid, in_ready, raw_temperature,      | to block
//         | raw_pressure                              |
// out     | out_valid, out_ready, temperature_        | from block
//         | decidegrees, pressure_pascal, divide_error|
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | to block
//
// one beat accepted per cycle while no result is held on out; a result passes
// through the two 32-stage divider pipelines and 18 arithmetic stages
// the whole pipeline moves together and holds while a result waits on out
// cfg_ready is always high; reset clears valid bits and the coefficients,
// oversampling resets to 3
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [15:0]                          raw_temperature,
	input  logic [23:0]                          raw_pressure,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [15:0]                   temperature_decidegrees,
	output logic signed [20:0]                   pressure_pascal,
	output logic                                 divide_error,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                          cfg_data
);

	// coefficient registers
	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
			oss_q  <= bpc_pkg::C_OSS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (bpc_pkg::cfg_idx_t'(cfg_index))
				bpc_pkg::CFG_AC1_AC2:   ac12_q <= cfg_data;
				bpc_pkg::CFG_AC3_AC4:   ac34_q <= cfg_data;
				bpc_pkg::CFG_AC5_AC6:   ac56_q <= cfg_data;
				bpc_pkg::CFG_B1_B2:     b12_q  <= cfg_data;
				bpc_pkg::CFG_MC_MD:     mcmd_q <= cfg_data;
				bpc_pkg::CFG_OVERSAMPL: oss_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = bpc_pkg::sx16(ac12_q[31:16]);
	assign ac2 = bpc_pkg::sx16(ac12_q[15:0]);
	assign ac3 = bpc_pkg::sx16(ac34_q[31:16]);
	assign ac4 = {16'd0, ac34_q[15:0]};
	assign ac5 = {16'd0, ac56_q[31:16]};
	assign ac6 = {16'd0, ac56_q[15:0]};
	assign b1  = bpc_pkg::sx16(b12_q[31:16]);
	assign b2  = bpc_pkg::sx16(b12_q[15:0]);
	assign mc  = bpc_pkg::sx16(mcmd_q[31:16]);
	assign md  = bpc_pkg::sx16(mcmd_q[15:0]);

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// valid bits of the arithmetic stages
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6, v7_s7, v8_s8, v9_s9;
	logic v10_s10, v11_s11, v12_s12, v13_s13, v14_s14, v15_s15, v16_s16, v17_s17;
	logic d1_vld, d2_vld;

	// payload
	logic [31:0] ut_s1;
	logic [23:0] up_s1, up_s2, up_s3, up_s4;
	logic [31:0] x1_s2, x1_s3, den_s3, x1_s4;
	logic [31:0] ma_s4, mb_s4;
	logic        neg_s4, err_s3, err_s4;

	localparam int SIDE1_W = 32 + 24 + 2;
	logic [SIDE1_W-1:0] side1_in, side1_out;
	logic [31:0] q1;

	logic [31:0] x1_s5, x2_s5;
	logic [23:0] up_s5, up_s6, up_s7, up_s8, up_s9, up_s10;
	logic        err_s5, err_s6, err_s7, err_s8, err_s9, err_s10, err_s11, err_s12, err_s13;
	logic [31:0] t_s6, t_s7, t_s8, t_s9, t_s10, t_s11, t_s12, t_s13;
	logic [31:0] b6_s6, sq_s7, x2b_s7, x1c_s7, x2b_s8, x1c_s8, x1_s8, x2c_s8;
	logic [31:0] a_s9, x3b_s9, b3_s10, xs_s10, b4_s11, dp_s11;
	logic [31:0] b4_s12, b7_s12, dvd_s13, b4_s13;
	logic        dbl_s13;

	localparam int SIDE2_W = 32 + 2;
	logic [SIDE2_W-1:0] side2_in, side2_out;
	logic [31:0] q2;

	logic [31:0] t_s14, t_s15, t_s16, t_s17, p_s14, p_s15, p_s16, p_s17;
	logic        err_s14, err_s15, err_s16, err_s17;
	logic [31:0] sqp_s15, x2_s15, x1_s16, x2_s16;

	// combinational helpers
	logic [31:0] b5_c, sh_p_c, den_c, mul1_c, a_sh_c;
	assign b5_c   = x1_s5 + x2_s5;
	assign sh_p_c = 32'($signed(p_s14) >>> 8);
	assign den_c  = x1_s2 + md;
	assign mul1_c = ut_s1 * ac5;
	assign a_sh_c = (a_s9 << oss_q) + 32'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0; v2_s2 <= 1'b0; v3_s3 <= 1'b0; v4_s4 <= 1'b0;
			v5_s5 <= 1'b0; v6_s6 <= 1'b0; v7_s7 <= 1'b0; v8_s8 <= 1'b0;
			v9_s9 <= 1'b0; v10_s10 <= 1'b0; v11_s11 <= 1'b0; v12_s12 <= 1'b0;
			v13_s13 <= 1'b0; v14_s14 <= 1'b0; v15_s15 <= 1'b0; v16_s16 <= 1'b0;
			v17_s17 <= 1'b0; out_valid <= 1'b0;
		end else if (adv) begin
			v1_s1 <= in_valid; v2_s2 <= v1_s1; v3_s3 <= v2_s2; v4_s4 <= v3_s3;
			v5_s5 <= d1_vld; v6_s6 <= v5_s5; v7_s7 <= v6_s6; v8_s8 <= v7_s7;
			v9_s9 <= v8_s8; v10_s10 <= v9_s9; v11_s11 <= v10_s10;
			v12_s12 <= v11_s11; v13_s13 <= v12_s12;
			v14_s14 <= d2_vld; v15_s15 <= v14_s14; v16_s16 <= v15_s15;
			v17_s17 <= v16_s16; out_valid <= v17_s17;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// temperature front end
			ut_s1  <= {16'd0, raw_temperature} - ac6;
			up_s1  <= raw_pressure >> (4'd8 - {2'd0, oss_q});
			x1_s2  <= 32'($signed(mul1_c) >>> 15);
			up_s2  <= up_s1;
			den_s3 <= den_c;
			err_s3 <= (den_c == '0);
			x1_s3  <= x1_s2;
			up_s3  <= up_s2;
			ma_s4  <= mc[31] ? 32'd0 - (mc << 11) : (mc << 11);
			mb_s4  <= den_s3[31] ? 32'd0 - den_s3 : den_s3;
			neg_s4 <= mc[31] ^ den_s3[31];
			err_s4 <= err_s3;
			x1_s4  <= x1_s3;
			up_s4  <= up_s3;
			// after the temperature divider
			x2_s5  <= side1_out[1] ? 32'd0 - q1 : q1;
			{x1_s5, up_s5} <= side1_out[SIDE1_W-1:2];
			err_s5 <= side1_out[0];
			t_s6   <= 32'($signed(b5_c + 32'd8) >>> 4);
			b6_s6  <= b5_c - bpc_pkg::C_B6_OFFSET;
			up_s6  <= up_s5;
			err_s6 <= err_s5;
			sq_s7  <= 32'($signed(b6_s6 * b6_s6) >>> 12);
			x2b_s7 <= 32'($signed(ac2 * b6_s6) >>> 11);
			x1c_s7 <= 32'($signed(ac3 * b6_s6) >>> 13);
			t_s7   <= t_s6; up_s7 <= up_s6; err_s7 <= err_s6;
			x1_s8  <= 32'($signed(b2 * sq_s7) >>> 11);
			x2c_s8 <= 32'($signed(b1 * sq_s7) >>> 16);
			x2b_s8 <= x2b_s7; x1c_s8 <= x1c_s7;
			t_s8   <= t_s7; up_s8 <= up_s7; err_s8 <= err_s7;
			a_s9   <= (ac1 << 2) + x1_s8 + x2b_s8;
			x3b_s9 <= 32'($signed(x1c_s8 + x2c_s8 + 32'd2) >>> 2);
			t_s9   <= t_s8; up_s9 <= up_s8; err_s9 <= err_s8;
			b3_s10 <= 32'($signed(a_sh_c) >>> 2);
			xs_s10 <= x3b_s9 + bpc_pkg::C_X3_BIAS;
			t_s10  <= t_s9; up_s10 <= up_s9; err_s10 <= err_s9;
			b4_s11 <= (ac4 * xs_s10) >> 15;
			dp_s11 <= {8'd0, up_s10} - b3_s10;
			t_s11  <= t_s10; err_s11 <= err_s10;
			b7_s12 <= dp_s11 * (bpc_pkg::C_B7_SCALE >> oss_q);
			b4_s12 <= b4_s11;
			err_s12 <= err_s11 || (b4_s11 == '0);
			t_s12  <= t_s11;
			// large b7 is divided first, then doubled
			dbl_s13 <= (b7_s12 >= bpc_pkg::C_HALF_WRAP);
			dvd_s13 <= (b7_s12 >= bpc_pkg::C_HALF_WRAP) ? b7_s12 : (b7_s12 << 1);
			b4_s13  <= b4_s12;
			err_s13 <= err_s12;
			t_s13   <= t_s12;
			// after the pressure divider
			p_s14   <= side2_out[0] ? (q2 << 1) : q2;
			err_s14 <= side2_out[1];
			t_s14   <= side2_out[SIDE2_W-1:2];
			sqp_s15 <= sh_p_c * sh_p_c;
			x2_s15  <= 32'($signed(bpc_pkg::C_P_LIN_MUL * p_s14) >>> 16);
			p_s15   <= p_s14; t_s15 <= t_s14; err_s15 <= err_s14;
			x1_s16  <= 32'($signed(sqp_s15 * bpc_pkg::C_P_SQ_MUL) >>> 16);
			x2_s16  <= x2_s15;
			p_s16   <= p_s15; t_s16 <= t_s15; err_s16 <= err_s15;
			p_s17   <= p_s16 + 32'($signed(x1_s16 + x2_s16 + bpc_pkg::C_P_OFFSET) >>> 4);
			t_s17   <= t_s16; err_s17 <= err_s16;
			// saturate into the result register, or clear it on a divide error
			divide_error <= err_s17;
			if (err_s17) begin
				temperature_decidegrees <= '0;
				pressure_pascal         <= '0;
			end else begin
				if (t_s17[31:15] == {17{t_s17[31]}})
					temperature_decidegrees <= t_s17[15:0];
				else
					temperature_decidegrees <= t_s17[31] ? 16'sh8000 : 16'sh7FFF;
				if (p_s17[31:20] == {12{p_s17[31]}})
					pressure_pascal <= p_s17[20:0];
				else
					pressure_pascal <= p_s17[31] ? 21'sh100000 : 21'shFFFFF;
			end
		end
	end

	assign side1_in = {x1_s4, up_s4, neg_s4, err_s4};

	bpc_div #(.SIDE_W(SIDE1_W)) u_div_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v4_s4),
		.dividend  (ma_s4),
		.divisor   (mb_s4),
		.side_in   (side1_in),
		.out_valid (d1_vld),
		.quotient  (q1),
		.side_out  (side1_out)
	);

	assign side2_in = {t_s13, err_s13, dbl_s13};

	bpc_div #(.SIDE_W(SIDE2_W)) u_div_pres (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v13_s13),
		.dividend  (dvd_s13),
		.divisor   (b4_s13),
		.side_in   (side2_in),
		.out_valid (d2_vld),
		.quotient  (q2),
		.side_out  (side2_out)
	);

endmodule

FILE: hw/rtl/bpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_div
// pipelined unsigned 32 by 32 divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bpc_div #(
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [bpc_pkg::DIV_W-1:0]    dividend,
	input  logic [bpc_pkg::DIV_W-1:0]    divisor,
	input  logic [SIDE_W-1:0]            side_in,
	output logic                         out_valid,
	output logic [bpc_pkg::DIV_W-1:0]    quotient,
	output logic [SIDE_W-1:0]            side_out
);

	localparam int N = bpc_pkg::DIV_W;

	logic          vld_s  [1:N];
	logic [N-1:0]  rem_s  [1:N];
	logic [N-1:0]  num_s  [1:N];
	logic [N-1:0]  den_s  [1:N];
	logic [SIDE_W-1:0] side_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic          cur_vld;
		logic [N-1:0]  cur_rem;
		logic [N-1:0]  cur_num;
		logic [N-1:0]  cur_den;
		logic [SIDE_W-1:0] cur_side;
		logic [N:0]    trial;
		logic [N:0]    diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign cur_vld  = in_valid;
			assign cur_rem  = '0;
			assign cur_num  = dividend;
			assign cur_den  = divisor;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_vld  = vld_s[k];
			assign cur_rem  = rem_s[k];
			assign cur_num  = num_s[k];
			assign cur_den  = den_s[k];
			assign cur_side = side_s[k];
		end

		// restoring step: remainder stays below a nonzero divisor
		assign trial = {cur_rem, cur_num[N-1]};
		assign diff  = trial - {1'b0, cur_den};
		assign ge    = (trial >= {1'b0, cur_den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[N-1:0] : trial[N-1:0];
				num_s[k+1]  <= {cur_num[N-2:0], ge};
				den_s[k+1]  <= cur_den;
				side_s[k+1] <= cur_side;
			end
		end
	end

	assign out_valid = vld_s[N];
	assign quotient  = num_s[N];
	assign side_out  = side_s[N];

endmodule

FILE: hw/rtl/bpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_checker
// port level checks of the pressure compensation block
// ----------------------------------------------------------------------------
module bpc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] temperature_decidegrees,
	input logic signed [20:0] pressure_pascal,
	input logic               divide_error,
	input logic               cfg_valid,
	input logic               cfg_ready
);

	// a waiting result beat holds its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(temperature_decidegrees)
			&& $stable(pressure_pascal) && $stable(divide_error))
		else $error("result changed while stalled");

	// error results carry zero values
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_error |-> temperature_decidegrees == 16'sd0
			&& pressure_pascal == 21'sd0)
		else $error("error result with non-zero value");

	// with no result waiting the input side is open
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input blocked with free output");

	// input stalls only behind a held result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without cause");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration beat refused");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
	.clk                     (clk),
	.arst_n                  (arst_n),
	.in_ready                (in_ready),
	.out_valid               (out_valid),
	.out_ready               (out_ready),
	.temperature_decidegrees (temperature_decidegrees),
	.pressure_pascal         (pressure_pascal),
	.divide_error            (divide_error),
	.cfg_valid               (cfg_valid),
	.cfg_ready               (cfg_ready)
);
